FILE: hdl/apu_pkg.sv
package apu_pkg;

  localparam int DATA_W        = 8;
  localparam int CFG_W         = 15;
  localparam int ROW_W         = 14;
  localparam int IDX_W         = 2;
  localparam int APU_MAX_WIDTH = 16384;
  localparam int MAX_HEIGHT    = 16384;

  localparam logic [DATA_W-1:0] BYTE_MAX = 8'hff;

  localparam logic [1:0] MODE_NONE       = 2'd0;
  localparam logic [1:0] MODE_HORIZONTAL = 2'd1;
  localparam logic [1:0] MODE_VERTICAL   = 2'd2;
  localparam logic [1:0] MODE_GRADIENT   = 2'd3;

  localparam logic [IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic first_col;
    logic top_row;
    logic last;
  } pos_t;

endpackage

FILE: hdl/alpha_plane_unfilter.sv
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------
// input     | in_valid / in_ready  | filtered_value
// output    | out_valid / out_ready| alpha_value, last_of_image
// config    | cfg_we (no wait)     | cfg_index, cfg_data
//
// one request per cycle while the output is not stalled; a request is registered in the input
// stage, then in the output register; the line store read is issued at acceptance and its
// registered data meets the item in the input stage; predictor and add are combinational
// rst clears counters, neighbor bytes and valid flags; the line store is not cleared
// a stalled output holds its result while the input stage can still take one more
module alpha_plane_unfilter #(
  parameter int MAX_WIDTH = apu_pkg::APU_MAX_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [apu_pkg::DATA_W-1:0] filtered_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [apu_pkg::DATA_W-1:0] alpha_value,
  output logic                      last_of_image,
  input  logic                      cfg_we,
  input  logic [apu_pkg::IDX_W-1:0] cfg_index,
  input  logic [apu_pkg::CFG_W-1:0] cfg_data
);
  import apu_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [1:0]        filter_mode;
  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;

  logic              accept;
  logic              s1_fire;
  logic [COL_W-1:0]  col;
  pos_t              pos;

  logic              s1_valid;
  logic [DATA_W-1:0] s1_data;
  logic [COL_W-1:0]  s1_col;
  pos_t              s1_pos;

  logic [DATA_W-1:0] left_value;
  logic [DATA_W-1:0] above_left_value;
  logic [DATA_W-1:0] above;
  logic [DATA_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_NONE;
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE:  filter_mode  <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign accept   = in_valid && in_ready;

  apu_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .image_width  (image_width),
    .image_height (image_height),
    .col          (col),
    .pos          (pos)
  );

  apu_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (value),
    .rd_data (above)
  );

  apu_recon u_recon (
    .mode       (filter_mode),
    .pos        (s1_pos),
    .filtered   (s1_data),
    .left       (left_value),
    .above      (above),
    .above_left (above_left_value),
    .value      (value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= filtered_value;
      s1_col  <= col;
      s1_pos  <= pos;
    end
  end

  // neighbor bytes move on as each pixel leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_value       <= '0;
      above_left_value <= '0;
    end else if (s1_fire) begin
      left_value       <= value;
      above_left_value <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      alpha_value   <= value;
      last_of_image <= s1_pos.last;
    end
  end

endmodule

FILE: hdl/apu_line_store.sv
module apu_line_store #(
  parameter int DEPTH  = apu_pkg::APU_MAX_WIDTH,
  parameter int ADDR_W = 14
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [apu_pkg::DATA_W-1:0] wr_data,
  output logic [apu_pkg::DATA_W-1:0] rd_data
);
  import apu_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic              fwd;
  logic [DATA_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a read that meets a write to the same entry takes the new byte
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

FILE: hdl/apu_position.sv
module apu_position #(
  parameter int MAX_WIDTH = apu_pkg::APU_MAX_WIDTH,
  parameter int COL_W     = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [apu_pkg::CFG_W-1:0] image_width,
  input  logic [apu_pkg::CFG_W-1:0] image_height,
  output logic [COL_W-1:0]         col,
  output apu_pkg::pos_t            pos
);
  import apu_pkg::*;

  logic [ROW_W-1:0] row;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             last_col;
  logic             last_row;

  always_comb begin
    if (image_width == '0) begin
      w_eff = CFG_W'(1);
    end else if (image_width > CFG_W'(MAX_WIDTH)) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (image_height > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign last_col      = (CFG_W'(col) + CFG_W'(1)) >= w_eff;
  assign last_row      = (CFG_W'(row) + CFG_W'(1)) >= h_eff;
  assign pos.first_col = (col == '0);
  assign pos.top_row   = (row == '0);
  assign pos.last      = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (last_col && last_row) begin
        col <= '0;
        row <= '0;
      end else if (last_col) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

FILE: hdl/apu_recon.sv
module apu_recon (
  input  logic [1:0]                mode,
  input  apu_pkg::pos_t             pos,
  input  logic [apu_pkg::DATA_W-1:0] filtered,
  input  logic [apu_pkg::DATA_W-1:0] left,
  input  logic [apu_pkg::DATA_W-1:0] above,
  input  logic [apu_pkg::DATA_W-1:0] above_left,
  output logic [apu_pkg::DATA_W-1:0] value
);
  import apu_pkg::*;

  logic signed [DATA_W+1:0] grad;
  logic [DATA_W-1:0]        grad_clip;
  logic [DATA_W-1:0]        pred;

  assign grad = $signed({2'b00, left}) + $signed({2'b00, above})
              - $signed({2'b00, above_left});

  always_comb begin
    if (grad < 0) begin
      grad_clip = '0;
    end else if (grad > $signed({2'b00, BYTE_MAX})) begin
      grad_clip = BYTE_MAX;
    end else begin
      grad_clip = grad[DATA_W-1:0];
    end
  end

  // border rules hold in every mode except none
  always_comb begin
    if (mode == MODE_NONE || (pos.first_col && pos.top_row)) begin
      pred = '0;
    end else if (pos.first_col) begin
      pred = above;
    end else if (pos.top_row) begin
      pred = left;
    end else begin
      case (mode)
        MODE_HORIZONTAL: pred = left;
        MODE_VERTICAL:   pred = above;
        MODE_GRADIENT:   pred = grad_clip;
        default:         pred = '0;
      endcase
    end
  end

  assign value = pred + filtered;

endmodule

FILE: hdl/apu_checker.sv
module apu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [apu_pkg::DATA_W-1:0] alpha_value,
  input logic                      last_of_image,
  input logic                      cfg_we,
  input logic [apu_pkg::IDX_W-1:0] cfg_index,
  input logic [apu_pkg::CFG_W-1:0] cfg_data
);
  import apu_pkg::*;

  logic [CFG_W-1:0] width_seen;
  logic [CFG_W-1:0] height_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_seen  <= CFG_W'(1);
      height_seen <= CFG_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_seen <= cfg_data;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        height_seen <= cfg_data;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alpha_value) && $stable(last_of_image))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // with no result waiting, the input stage is empty or draining
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused while output side is free");

  a_single_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && width_seen <= CFG_W'(1) && height_seen <= CFG_W'(1) |-> last_of_image)
    else $error("one-pixel image without end flag");

endmodule

bind alpha_plane_unfilter apu_checker u_apu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .alpha_value   (alpha_value),
  .last_of_image (last_of_image),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data)
);
